// ----- rtl/sks_pkg.sv -----
// Shared constants and controller-datapath interface types for the stable key sorter.
package sks_pkg;

   // Default number of entries held by the store.
   localparam int DEPTH_DEFAULT = 512;

   // Field widths of one beat.
   localparam int KEY_W = 16;
   localparam int TAG_W = 16;

   // Request kinds.
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_READ = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_wr;    // store the request entry
      logic load_clear; // the entry opens a new set
      logic rd_issue;   // read the store at the read pointer
      logic out_entry;  // register the sorted entry just read
      logic out_empty;  // register an empty response
      logic sort_start; // first pass, run width of one
      logic run_setup;  // compute the bounds of the next pair of runs
      logic merge_wr;   // write the smaller head to the other bank
      logic next_run;   // step to the next pair of runs
      logic next_pass;  // double the run width and swap banks
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic have_entry;  // a sorted entry remains to be read
      logic fill_small;  // the set holds at most one entry
      logic run_done;    // this write is the last one of the pair of runs
      logic pass_done;   // no further pair of runs in this pass
      logic sort_done;   // the doubled run width covers the whole set
      logic out_blocked; // a response is held and the consumer stalls
   } status_type;

endpackage

// ----- rtl/sks_ctrl.sv -----
// Controller state machine: request handshake, read sequencing and merge-pass sequencing.
module sks_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic               req_last_load,
   input  sks_pkg::status_type status,
   output sks_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_RD_WAIT   = 3'd1;
   localparam logic [2:0] ST_SORT_INIT = 3'd2;
   localparam logic [2:0] ST_RUN_SETUP = 3'd3;
   localparam logic [2:0] ST_MERGE_RD  = 3'd4;
   localparam logic [2:0] ST_MERGE_WR  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       reading_ff;
   logic       reading_in;
   logic       accept;

   // Requests are taken only when idle; a read also needs room in the response register.
   assign req_stall = (state_ff != ST_IDLE) ||
                      ((req_kind == sks_pkg::KIND_READ) && status.out_blocked);
   assign accept    = req_valid && !req_stall;

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      reading_in = reading_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == sks_pkg::KIND_LOAD) begin
                  cmd.load_wr    = 1'b1;
                  cmd.load_clear = reading_ff;
                  reading_in     = 1'b0;
                  if (req_last_load) begin
                     state_in = ST_SORT_INIT;
                  end
               end else if (reading_ff && status.have_entry) begin
                  cmd.rd_issue = 1'b1;
                  state_in     = ST_RD_WAIT;
               end else begin
                  cmd.out_empty = 1'b1;
               end
            end
         end
         ST_RD_WAIT: begin
            cmd.out_entry = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_SORT_INIT: begin
            cmd.sort_start = 1'b1;
            if (status.fill_small) begin
               reading_in = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               state_in = ST_RUN_SETUP;
            end
         end
         ST_RUN_SETUP: begin
            cmd.run_setup = 1'b1;
            state_in      = ST_MERGE_RD;
         end
         ST_MERGE_RD: begin
            state_in = ST_MERGE_WR;
         end
         ST_MERGE_WR: begin
            cmd.merge_wr = 1'b1;
            if (status.run_done) begin
               if (status.pass_done) begin
                  cmd.next_pass = 1'b1;
                  if (status.sort_done) begin
                     reading_in = 1'b1;
                     state_in   = ST_IDLE;
                  end else begin
                     state_in = ST_RUN_SETUP;
                  end
               end else begin
                  cmd.next_run = 1'b1;
                  state_in     = ST_RUN_SETUP;
               end
            end else begin
               state_in = ST_MERGE_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         reading_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         reading_ff <= reading_in;
      end
   end

endmodule

// ----- rtl/sks_datapath.sv -----
// Datapath: two ping-pong store banks, merge pointers, key compare and response register.
module sks_datapath #(
   parameter int DEPTH = sks_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sks_pkg::cmd_type                  cmd,
   output sks_pkg::status_type               status,
   input  logic signed [sks_pkg::KEY_W-1:0]  load_key,
   input  logic        [sks_pkg::TAG_W-1:0]  load_tag,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic        [sks_pkg::TAG_W-1:0]  rsp_out_tag,
   output logic signed [sks_pkg::KEY_W-1:0]  rsp_out_key,
   output logic                              rsp_out_last,
   output logic                              rsp_empty_res
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = CW + 2;
   localparam int KW = sks_pkg::KEY_W;
   localparam int TW = sks_pkg::TAG_W;
   localparam int WW = KW + TW;

   // Store banks, one word holds key above tag.
   logic [WW-1:0] bank0_ff [DEPTH];
   logic [WW-1:0] bank1_ff [DEPTH];
   logic [WW-1:0] rda0_ff, rdb0_ff, rda1_ff, rdb1_ff;

   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] rp_ff, rp_in;
   logic [PW-1:0] base_ff, base_in;
   logic [PW-1:0] width_ff, width_in;
   logic [PW-1:0] mid_ff, mid_in;
   logic [PW-1:0] stop_ff, stop_in;
   logic [PW-1:0] a_ff, a_in;
   logic [PW-1:0] b_ff, b_in;
   logic [PW-1:0] o_ff, o_in;
   logic          sel_ff, sel_in;

   logic          valid_ff, valid_in;
   logic [TW-1:0] tag_ff, tag_in;
   logic [KW-1:0] key_ff, key_in;
   logic          last_ff, last_in;
   logic          empty_ff, empty_in;

   logic [PW-1:0] fill_ext;
   logic [PW-1:0] twice_w;
   logic [PW-1:0] run_mid;
   logic [PW-1:0] run_lim;
   logic [WW-1:0] rda, rdb, pick;
   logic signed [KW-1:0] key_a, key_b;
   logic          take_left;
   logic          full;
   logic          load_do;
   logic [AW-1:0] raddr_a, raddr_b, waddr;
   logic [WW-1:0] wdata;
   logic          we0, we1;
   logic          pop;

   // Run bounds and the head compare of the merge.
   always_comb begin
      fill_ext  = {2'b00, fill_ff};
      twice_w   = width_ff << 1;
      run_mid   = base_ff + width_ff;
      run_lim   = base_ff + twice_w;
      rda       = sel_ff ? rda1_ff : rda0_ff;
      rdb       = sel_ff ? rdb1_ff : rdb0_ff;
      key_a     = signed'(rda[WW-1:TW]);
      key_b     = signed'(rdb[WW-1:TW]);
      take_left = (a_ff < mid_ff) && ((b_ff >= stop_ff) || (key_a <= key_b));
      pick      = take_left ? rda : rdb;
   end

   // Store write and read ports.
   always_comb begin
      full    = (fill_ff == CW'(DEPTH));
      load_do = cmd.load_wr && (cmd.load_clear || !full);
      raddr_a = cmd.rd_issue ? rp_ff[AW-1:0] : a_ff[AW-1:0];
      raddr_b = b_ff[AW-1:0];
      if (cmd.merge_wr) begin
         waddr = o_ff[AW-1:0];
         wdata = pick;
      end else begin
         waddr = cmd.load_clear ? '0 : fill_ff[AW-1:0];
         wdata = {load_key, load_tag};
      end
      we0 = (load_do && !sel_ff) || (cmd.merge_wr && sel_ff);
      we1 = (load_do && sel_ff) || (cmd.merge_wr && !sel_ff);
   end

   always_ff @(posedge clock) begin
      if (we0) begin
         bank0_ff[waddr] <= wdata;
      end
      if (we1) begin
         bank1_ff[waddr] <= wdata;
      end
      rda0_ff <= bank0_ff[raddr_a];
      rdb0_ff <= bank0_ff[raddr_b];
      rda1_ff <= bank1_ff[raddr_a];
      rdb1_ff <= bank1_ff[raddr_b];
   end

   // Fill count, read pointer and merge pointers.
   always_comb begin
      fill_in  = fill_ff;
      rp_in    = rp_ff;
      base_in  = base_ff;
      width_in = width_ff;
      mid_in   = mid_ff;
      stop_in  = stop_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      o_in     = o_ff;
      sel_in   = sel_ff;
      if (cmd.load_wr) begin
         if (cmd.load_clear) begin
            fill_in = CW'(1);
         end else if (!full) begin
            fill_in = fill_ff + CW'(1);
         end
      end
      if (cmd.load_clear || cmd.sort_start) begin
         rp_in = '0;
      end else if (cmd.out_entry) begin
         rp_in = rp_ff + CW'(1);
      end
      if (cmd.sort_start) begin
         base_in  = '0;
         width_in = PW'(1);
      end
      if (cmd.run_setup) begin
         mid_in  = (run_mid < fill_ext) ? run_mid : fill_ext;
         stop_in = (run_lim < fill_ext) ? run_lim : fill_ext;
         a_in    = base_ff;
         b_in    = (run_mid < fill_ext) ? run_mid : fill_ext;
         o_in    = base_ff;
      end
      if (cmd.merge_wr) begin
         o_in = o_ff + PW'(1);
         if (take_left) begin
            a_in = a_ff + PW'(1);
         end else begin
            b_in = b_ff + PW'(1);
         end
      end
      if (cmd.next_run) begin
         base_in = run_lim;
      end
      if (cmd.next_pass) begin
         base_in  = '0;
         width_in = twice_w;
         sel_in   = !sel_ff;
      end
   end

   // Response register: a held beat leaves when the consumer does not stall.
   always_comb begin
      pop      = valid_ff && !rsp_stall;
      valid_in = valid_ff && !pop;
      tag_in   = tag_ff;
      key_in   = key_ff;
      last_in  = last_ff;
      empty_in = empty_ff;
      if (cmd.out_entry) begin
         valid_in = 1'b1;
         tag_in   = rda[TW-1:0];
         key_in   = rda[WW-1:TW];
         last_in  = (rp_ff + CW'(1) == fill_ff);
         empty_in = 1'b0;
      end else if (cmd.out_empty) begin
         valid_in = 1'b1;
         tag_in   = '0;
         key_in   = '0;
         last_in  = 1'b0;
         empty_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         rp_ff    <= '0;
         base_ff  <= '0;
         width_ff <= '0;
         mid_ff   <= '0;
         stop_ff  <= '0;
         a_ff     <= '0;
         b_ff     <= '0;
         o_ff     <= '0;
         sel_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         rp_ff    <= rp_in;
         base_ff  <= base_in;
         width_ff <= width_in;
         mid_ff   <= mid_in;
         stop_ff  <= stop_in;
         a_ff     <= a_in;
         b_ff     <= b_in;
         o_ff     <= o_in;
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff   <= tag_in;
      key_ff   <= key_in;
      last_ff  <= last_in;
      empty_ff <= empty_in;
   end

   // Status to the controller.
   always_comb begin
      status.have_entry  = (rp_ff < fill_ff);
      status.fill_small  = (fill_ff <= CW'(1));
      status.run_done    = (o_ff + PW'(1) == stop_ff);
      status.pass_done   = (run_lim >= fill_ext);
      status.sort_done   = (twice_w >= fill_ext);
      status.out_blocked = valid_ff && rsp_stall;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_tag   = tag_ff;
   assign rsp_out_key   = signed'(key_ff);
   assign rsp_out_last  = last_ff;
   assign rsp_empty_res = empty_ff;

endmodule

// ----- rtl/stable_key_sorter_core.sv -----
// Loads are written to the store as taken. Reads pass a registered store read, then the
// response register; an empty read goes straight there. The last load starts a bottom-up
// merge sort of ceil(log2 n) passes after a start state, each with a setup state per pair of
// runs and a read and a write state per entry; requests stall meanwhile and a set of one entry
// takes only the start state. Reset clears the controller, fill count, pointers and response
// register; store contents stay undefined and no clearing pass runs.
module stable_key_sorter_core #(
   parameter int DEPTH = sks_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_kind,
   input  logic signed [sks_pkg::KEY_W-1:0]  req_sort_key,
   input  logic        [sks_pkg::TAG_W-1:0]  req_tag,
   input  logic                              req_last_load,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic        [sks_pkg::TAG_W-1:0]  rsp_out_tag,
   output logic signed [sks_pkg::KEY_W-1:0]  rsp_out_key,
   output logic                              rsp_out_last,
   output logic                              rsp_empty_res
);

   sks_pkg::cmd_type    cmd;
   sks_pkg::status_type status;

   // Sequencing of beats and merge passes.
   sks_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_last_load (req_last_load),
      .status        (status),
      .cmd           (cmd)
   );

   // Store, merge pointers and response register.
   sks_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .load_key      (req_sort_key),
      .load_tag      (req_tag),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_out_tag   (rsp_out_tag),
      .rsp_out_key   (rsp_out_key),
      .rsp_out_last  (rsp_out_last),
      .rsp_empty_res (rsp_empty_res)
   );

endmodule

// ----- tb/tb_stable_key_sorter_core.sv -----
// Self-checking testbench for the stable key sorter core, with its own sort predictor.
module tb_stable_key_sorter_core;

   localparam int DEPTH = sks_pkg::DEPTH_DEFAULT;
   localparam int KEY_W = sks_pkg::KEY_W;
   localparam int TAG_W = sks_pkg::TAG_W;
   localparam logic KIND_LOAD = sks_pkg::KIND_LOAD;
   localparam logic KIND_READ = sks_pkg::KIND_READ;
   localparam int ITEM_TARGET = 2000;
   // Slowest sort of a full store, padded well beyond the stall and gap allowances.
   localparam int STALL_LIMIT = 6 * (2 * DEPTH * ($clog2(DEPTH) + 1) + 2 * DEPTH + 64);
   localparam int DRAIN_CYCLES = 10;

   typedef enum logic {PH_LOADING, PH_READING} sort_phase_type;

   typedef struct packed {
      logic [TAG_W-1:0]        tag;
      logic signed [KEY_W-1:0] key;
      logic                    last;
      logic                    empty;
   } sorted_beat_type;

   typedef struct packed {
      logic                    kind;
      logic signed [KEY_W-1:0] key;
      logic [TAG_W-1:0]        tag;
      logic                    last;
      logic                    known;
      sorted_beat_type         want;
   } script_row_type;

   localparam sorted_beat_type NO_BEAT    = '0;
   localparam sorted_beat_type EMPTY_BEAT = '{16'h0000, 16'sh0000, 1'b0, 1'b1};

   // Directed opening: extremes, stability on equal keys, and corners of the phases.
   localparam script_row_type SCRIPT [25] = '{
      // Read straight after reset finds nothing.
      '{KIND_READ, 16'sh0000, 16'h0000, 1'b0, 1'b1, EMPTY_BEAT},
      '{KIND_LOAD, 16'sh8000, 16'hFFFF, 1'b0, 1'b0, NO_BEAT},
      // Read while loading, with every ignored field set.
      '{KIND_READ, 16'shFFFF, 16'hFFFF, 1'b1, 1'b1, EMPTY_BEAT},
      '{KIND_LOAD, 16'sh7FFF, 16'h0000, 1'b1, 1'b0, NO_BEAT},
      '{KIND_READ, 16'sh0000, 16'h0000, 1'b0, 1'b1, '{16'hFFFF, 16'sh8000, 1'b0, 1'b0}},
      '{KIND_READ, 16'sh0000, 16'h0000, 1'b0, 1'b1, '{16'h0000, 16'sh7FFF, 1'b1, 1'b0}},
      // Reads past the end stay empty.
      '{KIND_READ, 16'sh0000, 16'h0000, 1'b0, 1'b1, EMPTY_BEAT},
      '{KIND_READ, 16'sh1234, 16'h5678, 1'b1, 1'b1, EMPTY_BEAT},
      // A set of one entry.
      '{KIND_LOAD, 16'sh0000, 16'h1234, 1'b1, 1'b0, NO_BEAT},
      '{KIND_READ, 16'sh0000, 16'h0000, 1'b0, 1'b1, '{16'h1234, 16'sh0000, 1'b1, 1'b0}},
      '{KIND_READ, 16'sh0000, 16'h0000, 1'b0, 1'b1, EMPTY_BEAT},
      // Equal keys must keep their load order.
      '{KIND_LOAD, 16'sh0005, 16'h00A1, 1'b0, 1'b0, NO_BEAT},
      '{KIND_LOAD, 16'sh0005, 16'h00A2, 1'b0, 1'b0, NO_BEAT},
      '{KIND_LOAD, 16'shFFFF, 16'h00A3, 1'b0, 1'b0, NO_BEAT},
      '{KIND_LOAD, 16'sh0005, 16'h00A4, 1'b1, 1'b0, NO_BEAT},
      '{KIND_READ, 16'sh0000, 16'h0000, 1'b0, 1'b0, NO_BEAT},
      '{KIND_READ, 16'sh0000, 16'h0000, 1'b0, 1'b0, NO_BEAT},
      // A load while reading drops the rest of the set and starts afresh.
      '{KIND_LOAD, 16'sh0007, 16'h00E1, 1'b1, 1'b0, NO_BEAT},
      '{KIND_READ, 16'sh0000, 16'h0000, 1'b0, 1'b1, '{16'h00E1, 16'sh0007, 1'b1, 1'b0}},
      '{KIND_READ, 16'sh0000, 16'h0000, 1'b0, 1'b1, EMPTY_BEAT},
      '{KIND_LOAD, 16'sh0003, 16'h00B1, 1'b0, 1'b0, NO_BEAT},
      '{KIND_READ, 16'sh0000, 16'h0000, 1'b0, 1'b1, EMPTY_BEAT},
      '{KIND_LOAD, 16'sh0003, 16'h00B2, 1'b0, 1'b0, NO_BEAT},
      '{KIND_LOAD, 16'shFFFD, 16'h00B3, 1'b1, 1'b0, NO_BEAT},
      '{KIND_READ, 16'sh0000, 16'h0000, 1'b0, 1'b0, NO_BEAT}
   };

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic                    req_kind;
   logic signed [KEY_W-1:0] req_sort_key;
   logic [TAG_W-1:0]        req_tag;
   logic                    req_last_load;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [TAG_W-1:0]        rsp_out_tag;
   logic signed [KEY_W-1:0] rsp_out_key;
   logic                    rsp_out_last;
   logic                    rsp_empty_res;

   // Predictor state: the held set, its sorted order and the read position.
   logic signed [KEY_W-1:0] held_key [DEPTH];
   logic [TAG_W-1:0]        held_tag [DEPTH];
   logic signed [KEY_W-1:0] merged_key [DEPTH];
   logic [TAG_W-1:0]        merged_tag [DEPTH];
   int                      held_count = 0;
   int                      next_out = 0;
   sort_phase_type          model_phase = PH_LOADING;

   sorted_beat_type         pending_beats [$];
   int                      mismatches = 0;
   int                      items_sent = 0;
   int                      idle_cycles = 0;
   int                      req_calm = 0;
   int                      rsp_calm = 0;

   stable_key_sorter_core #(.DEPTH(DEPTH)) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_sort_key  (req_sort_key),
      .req_tag       (req_tag),
      .req_last_load (req_last_load),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_tag   (rsp_out_tag),
      .rsp_out_key   (rsp_out_key),
      .rsp_out_last  (rsp_out_last),
      .rsp_empty_res (rsp_empty_res)
   );

   always #4 clock = ~clock;

   // Gap before the next beat: a random wait, with occasional stretches of no gaps at all.
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 5);
   endfunction

   // Bottom-up stable merge of the held set, run width doubling from one.
   function automatic void sort_held();
      int run;
      int lo;
      int mid;
      int hi;
      int a;
      int b;
      int o;
      bit pick_left;
      for (run = 1; run < held_count; run = run * 2) begin
         for (lo = 0; lo < held_count; lo += 2 * run) begin
            mid = (lo + run < held_count) ? lo + run : held_count;
            hi = (lo + 2 * run < held_count) ? lo + 2 * run : held_count;
            a = lo;
            b = mid;
            for (o = lo; o < hi; o++) begin
               if (a >= mid) begin
                  pick_left = 1'b0;
               end else if (b >= hi) begin
                  pick_left = 1'b1;
               end else begin
                  pick_left = (held_key[a] <= held_key[b]);
               end
               if (pick_left) begin
                  merged_key[o] = held_key[a];
                  merged_tag[o] = held_tag[a];
                  a++;
               end else begin
                  merged_key[o] = held_key[b];
                  merged_tag[o] = held_tag[b];
                  b++;
               end
            end
         end
         for (o = 0; o < held_count; o++) begin
            held_key[o] = merged_key[o];
            held_tag[o] = merged_tag[o];
         end
      end
   endfunction

   // Advances the predictor by one accepted request beat.
   function automatic void step_sorter(input logic kind, input logic signed [KEY_W-1:0] key,
                                       input logic [TAG_W-1:0] tag, input logic last,
                                       output bit produced, output sorted_beat_type res);
      res = '0;
      produced = 1'b0;
      if (kind == KIND_LOAD) begin
         if (model_phase != PH_LOADING) begin
            model_phase = PH_LOADING;
            held_count = 0;
            next_out = 0;
         end
         // A full store drops the entry but still honours its end mark.
         if (held_count < DEPTH) begin
            held_key[held_count] = key;
            held_tag[held_count] = tag;
            held_count++;
         end
         if (last) begin
            sort_held();
            next_out = 0;
            model_phase = PH_READING;
         end
      end else begin
         produced = 1'b1;
         if (model_phase == PH_READING && next_out < held_count) begin
            res.tag = held_tag[next_out];
            res.key = held_key[next_out];
            res.last = (next_out + 1 == held_count);
            next_out++;
         end else begin
            res.empty = 1'b1;
         end
      end
   endfunction

   function automatic logic signed [KEY_W-1:0] draw_key(input int flavour);
      logic signed [KEY_W-1:0] k;
      case (flavour)
         0: k = 16'($urandom_range(0, 4)) - 16'd2;
         1: begin
            case ($urandom_range(0, 4))
               0: k = 16'sh8000;
               1: k = 16'shFFFF;
               2: k = 16'sh0000;
               3: k = 16'sh0001;
               default: k = 16'sh7FFF;
            endcase
         end
         default: k = 16'($urandom);
      endcase
      return k;
   endfunction

   // Presents one request beat, holds it until accepted, then records what it should yield.
   task automatic send_beat(input logic kind, input logic signed [KEY_W-1:0] key,
                            input logic [TAG_W-1:0] tag, input logic last,
                            input logic known, input sorted_beat_type want);
      int gap;
      bit produced;
      sorted_beat_type got;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_sort_key <= key;
      req_tag <= tag;
      req_last_load <= last;
      do @(posedge clock); while (req_stall !== 1'b0);
      step_sorter(kind, key, tag, last, produced, got);
      if (produced) begin
         pending_beats.push_back(known ? want : got);
      end
      items_sent++;
   endtask

   task automatic send_read();
      send_beat(KIND_READ, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)), 1'b0, NO_BEAT);
   endtask

   task automatic note_mismatch(input string field, input logic signed [31:0] want,
                                input logic signed [31:0] got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
   endtask

   // Stimulus: reset, the directed script, then random sets of loads and reads.
   initial begin
      int set_no;
      int n;
      int reads;
      int pick;
      int flavour;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_LOAD;
      req_sort_key = '0;
      req_tag = '0;
      req_last_load = 1'b0;
      rsp_stall = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (SCRIPT[r]) begin
         send_beat(SCRIPT[r].kind, SCRIPT[r].key, SCRIPT[r].tag, SCRIPT[r].last,
                   SCRIPT[r].known, SCRIPT[r].want);
      end

      set_no = 0;
      while (items_sent < ITEM_TARGET) begin
         // One set overfills the store; the rest stay small.
         if (set_no == 2) begin
            n = DEPTH + $urandom_range(1, 4);
         end else if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 40);
         end else begin
            n = $urandom_range(1, 10);
         end
         flavour = $urandom_range(0, 2);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0) begin
               send_read();
            end
            send_beat(KIND_LOAD, draw_key(flavour), 16'($urandom), i == n - 1, 1'b0, NO_BEAT);
         end
         // Mostly read the whole set and a little past it; sometimes abandon it early.
         pick = $urandom_range(0, 19);
         if (pick < 12) begin
            reads = n + $urandom_range(0, 2);
         end else if (pick < 17) begin
            reads = $urandom_range(0, n);
         end else begin
            reads = 0;
         end
         for (int i = 0; i < reads; i++) begin
            send_read();
         end
         // Occasional noise beats of any kind.
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) begin
               send_beat(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                         $urandom_range(0, 3) == 0, 1'b0, NO_BEAT);
            end
         end
         set_no++;
      end
      req_valid <= 1'b0;

      while (pending_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_stable_key_sorter_core OK");
      end else begin
         $display("tb_stable_key_sorter_core NOT OK");
      end
      $finish;
   end

   // Response side: random stalls, and each accepted beat checked against the oldest prediction.
   initial begin
      int hold;
      sorted_beat_type want;
      repeat (3) @(posedge clock);
      forever begin
         hold = draw_wait(rsp_calm);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1 || rsp_stall !== 1'b0);
         if (pending_beats.size() == 0) begin
            $display("%0t: unexpected response beat, expected none, actual tag %h key %0d last %b empty %b",
                     $time, rsp_out_tag, rsp_out_key, rsp_out_last, rsp_empty_res);
            mismatches++;
         end else begin
            want = pending_beats.pop_front();
            if (rsp_out_tag !== want.tag) begin
               note_mismatch("out_tag", 32'(want.tag), 32'(rsp_out_tag));
            end
            if (rsp_out_key !== want.key) begin
               note_mismatch("out_key", 32'(want.key), 32'(rsp_out_key));
            end
            if (rsp_out_last !== want.last) begin
               note_mismatch("out_last", 32'(want.last), 32'(rsp_out_last));
            end
            if (rsp_empty_res !== want.empty) begin
               note_mismatch("empty_res", 32'(want.empty), 32'(rsp_empty_res));
            end
         end
      end
   end

   // Watchdog: too long without a beat on either channel means the block has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
         $display("tb_stable_key_sorter_core NOT OK");
         $finish;
      end
   end

endmodule

// ----- sim.f -----
rtl/sks_pkg.sv
rtl/sks_ctrl.sv
rtl/sks_datapath.sv
rtl/stable_key_sorter_core.sv
tb/tb_stable_key_sorter_core.sv
